### hw/rtl/gks_pkg.sv
`timescale 1ns / 1ps
// gks_pkg: widths, stored entry type and sequencer states of the greedy knapsack selector
// no dependencies

package gks_pkg;

    localparam int MAX_FILES_DEF = 32;

    localparam int ID_W     = 16;
    localparam int SIZE_W   = 16;
    localparam int IMP_W    = 7;
    localparam int RISK_W   = 7;
    localparam int WEIGHT_W = IMP_W + RISK_W;
    localparam int PROD_W   = WEIGHT_W + SIZE_W;
    localparam int CAP_W    = 21;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;
    localparam int M_USER_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1000);

    // one stored item, weight = importance * risk worked out at load
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [SIZE_W-1:0]   size;
        logic [WEIGHT_W-1:0] weight;
    } gks_entry_t;

    typedef enum logic [5:0] {
        ST_LOAD   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_MUL_A  = 6'b000100,
        ST_MUL_B  = 6'b001000,
        ST_PLACE  = 6'b010000,
        ST_FINISH = 6'b100000
    } gks_state_t;

endpackage

### hw/rtl/greedy_knapsack_selector.sv
`timescale 1ns / 1ps
// greedy_knapsack_selector: loads items, ranks them by importance*risk/size and fills capacity
// depends on gks_pkg

// usage
//   s_ channel: one beat per item, s_tdata = item_id, item_size, importance, risk
//   (lowest bits first), s_tlast marks the last item of a dataset and starts selection
//   m_ channel: one beat per chosen item in rank order with the running total used;
//   m_tlast marks the last beat of the dataset, m_tuser[0] = nothing chosen,
//   m_tuser[1] = more than MAX_FILES items were offered
//   cfg_w channel: writes capacity_mb, always ready; write only while the block is idle
// timing
//   loading accepts one item per cycle; items past MAX_FILES are dropped and flagged
//   selection runs N ranks, each a scan over the N stored items through one memory
//   read port and one shared 14x16 multiplier: each item scanned is read and then
//   multiplied, a compare against the current best takes a second multiply, and each
//   rank ends with a placement step; a finish step then hands over the final result
//   s_tready stays low from the last beat until the final result is in the output register
// reset: aresetn (synchronous, active low) empties the dataset, capacity returns to 1000
// stall: a result waits in the output register; the sequencer holds when it has a
//   second result to hand over and the receiver has not taken the first

module greedy_knapsack_selector
    import gks_pkg::*;
#(
    parameter int MAX_FILES = MAX_FILES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // item beat: [15:0] item_id, [31:16] item_size, [38:32] importance, [45:39] risk
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tlast,
    // result beat: [15:0] chosen_id, [31:16] chosen_size, [52:32] used_total
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    // result flags: [0] none_chosen, [1] dropped_items
    output logic [M_USER_W-1:0] m_tuser,
    output logic                m_tlast,
    // capacity_mb write
    input  logic                cfg_wvalid,
    output logic                cfg_wready,
    input  logic [CAP_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_FILES);
    localparam int CNT_W = $clog2(MAX_FILES + 1);

    // item storage, written at load, read one entry per scan step
    gks_entry_t mem [MAX_FILES];
    gks_entry_t rd_reg;

    gks_state_t state_reg, state_next;

    logic [CAP_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 overflow_reg, overflow_next;
    logic [MAX_FILES-1:0] taken_reg, taken_next;

    // scan position, rank counter and current best of the scan
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     rank_reg, rank_next;
    logic                 best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    gks_entry_t           best_reg, best_next;
    logic [PROD_W-1:0]    lhs_reg, lhs_next;

    // running total and result held back until the next one shows whether it is last
    logic [CAP_W-1:0]     used_reg, used_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic [SIZE_W-1:0]    pend_size_reg, pend_size_next;
    logic [CAP_W-1:0]     pend_used_reg, pend_used_next;

    // output register
    logic                 m_vld_reg, m_vld_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [M_USER_W-1:0]  m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;

    logic                 s_accept;
    logic                 room;
    logic                 out_free;
    logic                 scan_last;
    logic [WEIGHT_W-1:0]  mul_a;
    logic [SIZE_W-1:0]    mul_b;
    logic [PROD_W-1:0]    prod;
    logic [CAP_W:0]       fit_sum;
    logic                 fits;

    assign s_tready   = (state_reg == ST_LOAD);
    assign s_accept   = s_tvalid && s_tready;
    assign room       = (count_reg < CNT_W'(MAX_FILES));
    assign cfg_wready = 1'b1;
    assign out_free   = !m_vld_reg || m_tready;
    assign scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // shared multiplier: first w_i * size_best, then w_best * size_i
    assign mul_a = (state_reg == ST_MUL_A) ? rd_reg.weight : best_reg.weight;
    assign mul_b = (state_reg == ST_MUL_A) ? best_reg.size : rd_reg.size;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign fit_sum = {1'b0, used_reg} + (CAP_W + 1)'(best_reg.size);
    assign fits    = (fit_sum <= {1'b0, cap_reg});

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (s_accept && room) begin
            mem[count_reg[IDX_W-1:0]] <= '{
                id:     s_tdata[15:0],
                size:   s_tdata[31:16],
                weight: WEIGHT_W'(s_tdata[38:32]) * WEIGHT_W'(s_tdata[45:39])
            };
        end
        rd_reg <= mem[idx_reg];
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        taken_next     = taken_reg;
        idx_next       = idx_reg;
        rank_next      = rank_reg;
        best_vld_next  = best_vld_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        lhs_next       = lhs_reg;
        used_next      = used_reg;
        pend_vld_next  = pend_vld_reg;
        pend_id_next   = pend_id_reg;
        pend_size_next = pend_size_reg;
        pend_used_next = pend_used_reg;
        m_vld_next     = m_vld_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (room) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_tlast) begin
                        idx_next      = '0;
                        rank_next     = '0;
                        best_vld_next = 1'b0;
                        used_next     = '0;
                        pend_vld_next = 1'b0;
                        taken_next    = '0;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // empty dataset cannot rank anything
                state_next = (count_reg == '0) ? ST_FINISH : ST_MUL_A;
            end
            ST_MUL_A: begin
                if (taken_reg[idx_reg]) begin
                    state_next = ST_READ;
                end else if (!best_vld_reg) begin
                    best_vld_next = 1'b1;
                    best_idx_next = idx_reg;
                    best_next     = rd_reg;
                    state_next    = ST_READ;
                end else begin
                    lhs_next   = prod;
                    state_next = ST_MUL_B;
                end
                if (state_next == ST_READ) begin
                    if (scan_last) begin
                        state_next = ST_PLACE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_MUL_B: begin
                // strict win only, so ties stay with the earlier item
                if (lhs_reg > prod) begin
                    best_idx_next = idx_reg;
                    best_next     = rd_reg;
                end
                if (scan_last) begin
                    state_next = ST_PLACE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_PLACE: begin
                if (!fits || !pend_vld_reg || out_free) begin
                    taken_next[best_idx_reg] = 1'b1;
                    if (fits) begin
                        if (pend_vld_reg) begin
                            m_vld_next  = 1'b1;
                            m_data_next = {3'b000, pend_used_reg, pend_size_reg, pend_id_reg};
                            m_user_next = {overflow_reg, 1'b0};
                            m_last_next = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_id_next   = best_reg.id;
                        pend_size_next = best_reg.size;
                        pend_used_next = fit_sum[CAP_W-1:0];
                        used_next      = fit_sum[CAP_W-1:0];
                    end
                    rank_next     = rank_reg + CNT_W'(1);
                    idx_next      = '0;
                    best_vld_next = 1'b0;
                    if ((rank_reg + CNT_W'(1)) == count_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_vld_next  = 1'b1;
                    m_last_next = 1'b1;
                    if (pend_vld_reg) begin
                        m_data_next = {3'b000, pend_used_reg, pend_size_reg, pend_id_reg};
                        m_user_next = {overflow_reg, 1'b0};
                    end else begin
                        m_data_next = '0;
                        m_user_next = {overflow_reg, 1'b1};
                    end
                    count_next    = '0;
                    overflow_next = 1'b0;
                    taken_next    = '0;
                    pend_vld_next = 1'b0;
                    idx_next      = '0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cap_reg      <= CAP_RESET;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            taken_reg    <= '0;
            idx_reg      <= '0;
            rank_reg     <= '0;
            best_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            used_reg     <= '0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wvalid && cfg_wready) begin
                cap_reg <= cfg_wdata;
            end
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            taken_reg    <= taken_next;
            idx_reg      <= idx_next;
            rank_reg     <= rank_next;
            best_vld_reg <= best_vld_next;
            pend_vld_reg <= pend_vld_next;
            used_reg     <= used_next;
            m_vld_reg    <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        lhs_reg       <= lhs_next;
        pend_id_reg   <= pend_id_next;
        pend_size_reg <= pend_size_next;
        pend_used_reg <= pend_used_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for greedy_knapsack_selector, random datasets and capacities
// depends on gks_pkg and the greedy_knapsack_selector rtl

module tb_top;
    import gks_pkg::*;

    localparam int SLOTS       = MAX_FILES_DEF;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_WAIT  = 3200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    // one input beat as the predictor sees it
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] mb;
        logic [IMP_W-1:0]  imp;
        logic [RISK_W-1:0] risk;
        logic              ends_set;
    } file_beat_t;

    // one result beat
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] mb;
        logic [CAP_W-1:0]  used;
        logic              none;
        logic              dropped;
        logic              ends_set;
    } pick_t;

    // predictor of the ranking and fill, plus the queue of picks still owed
    class selection_board;
        logic [CAP_W-1:0] capacity;
        file_beat_t       held[SLOTS];
        int               held_count;
        bit               overflow;
        pick_t            queued_picks[$];
        int               errors;

        function new();
            capacity   = CAP_RESET;
            held_count = 0;
            overflow   = 0;
            errors     = 0;
        endfunction

        // a beats b when imp_a*risk_a*size_b > imp_b*risk_b*size_a
        function bit outranks(int a, int b);
            longint unsigned lhs, rhs;
            lhs = 64'(held[a].imp) * 64'(held[a].risk) * 64'(held[b].mb);
            rhs = 64'(held[b].imp) * 64'(held[b].risk) * 64'(held[a].mb);
            return lhs > rhs;
        endfunction

        // append a pick at the tail of the owed queue
        function void owe_pick(pick_t p);
            queued_picks.insert(queued_picks.size(), p);
        endfunction

        function void note_file(file_beat_t f);
            bit    placed[SLOTS];
            int    best;
            int    used;
            int    picks;
            pick_t p;
            if (held_count < SLOTS) begin
                held[held_count] = f;
                held_count++;
            end else begin
                overflow = 1;
            end
            if (!f.ends_set)
                return;
            foreach (placed[i])
                placed[i] = 0;
            used  = 0;
            picks = 0;
            for (int r = 0; r < held_count; r++) begin
                // first unranked item in load order that nothing later strictly beats
                best = -1;
                for (int i = 0; i < held_count; i++)
                    if (!placed[i] && (best < 0 || outranks(i, best)))
                        best = i;
                placed[best] = 1;
                if (used + int'(held[best].mb) <= int'(capacity)) begin
                    used      += int'(held[best].mb);
                    p.id       = held[best].id;
                    p.mb       = held[best].mb;
                    p.used     = CAP_W'(used);
                    p.none     = 0;
                    p.dropped  = overflow;
                    p.ends_set = 0;
                    owe_pick(p);
                    picks++;
                end
            end
            if (picks == 0) begin
                p         = '0;
                p.none    = 1;
                p.dropped = overflow;
                owe_pick(p);
            end
            p          = queued_picks.pop_back();
            p.ends_set = 1;
            owe_pick(p);
            held_count = 0;
            overflow   = 0;
        endfunction

        function void flag_field(string name, longint unsigned want_v, longint unsigned got_v);
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want_v, got_v);
            errors++;
        endfunction

        function void check_pick(pick_t got);
            pick_t want;
            if (queued_picks.size() == 0) begin
                $display("%0t unexpected result: expected nothing actual %h", $time, got);
                errors++;
                return;
            end
            want = queued_picks.pop_front();
            if (got.id !== want.id)             flag_field("chosen_id", want.id, got.id);
            if (got.mb !== want.mb)             flag_field("chosen_size", want.mb, got.mb);
            if (got.used !== want.used)         flag_field("used_total", want.used, got.used);
            if (got.none !== want.none)         flag_field("none_chosen", want.none, got.none);
            if (got.dropped !== want.dropped)
                flag_field("dropped_items", want.dropped, got.dropped);
            if (got.ends_set !== want.ends_set)
                flag_field("last_result", want.ends_set, got.ends_set);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;
    logic                cfg_wvalid;
    logic                cfg_wready;
    logic [CAP_W-1:0]    cfg_wdata;

    selection_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;

    greedy_knapsack_selector #(
        .MAX_FILES(SLOTS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wvalid(cfg_wvalid),
        .cfg_wready(cfg_wready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // run guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        pick_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.id       = m_tdata[15:0];
            got.mb       = m_tdata[31:16];
            got.used     = m_tdata[52:32];
            got.none     = m_tuser[0];
            got.dropped  = m_tuser[1];
            got.ends_set = m_tlast;
            board.check_pick(got);
        end
    end

    function automatic file_beat_t make_file(logic [15:0] id, logic [15:0] mb,
                                             logic [6:0] imp, logic [6:0] risk, logic ends_set);
        file_beat_t f;
        f.id       = id;
        f.mb       = mb;
        f.imp      = imp;
        f.risk     = risk;
        f.ends_set = ends_set;
        return f;
    endfunction

    // mostly in-range values, sometimes the full field width, sometimes an exact tie
    function automatic file_beat_t random_file(file_beat_t prev, bit ends_set);
        file_beat_t f;
        int pick;
        f.id = 16'($urandom_range(65535));
        pick = $urandom_range(9);
        if (pick < 8)
            f.mb = 16'($urandom_range(1, 2000));
        else if (pick == 8)
            f.mb = 16'($urandom_range(0, 65535));
        else
            f.mb = 16'($urandom_range(0, 20));
        f.imp  = ($urandom_range(99) < 85) ? 7'($urandom_range(10, 100)) : 7'($urandom_range(127));
        f.risk = ($urandom_range(99) < 85) ? 7'($urandom_range(0, 100)) : 7'($urandom_range(127));
        if ($urandom_range(99) < 15) begin
            f.mb   = prev.mb;
            f.imp  = prev.imp;
            f.risk = prev.risk;
        end
        f.ends_set = ends_set;
        return f;
    endfunction

    function automatic logic [CAP_W-1:0] random_capacity();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CAP_W'(1);
            2:       return CAP_MAX;
            3:       return CAP_W'($urandom_range(0, 2097151));
            default: return CAP_W'($urandom_range(1, 4000));
        endcase
    endfunction

    function automatic int dataset_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return $urandom_range(1, 8);
        else if (pick < 95)
            return $urandom_range(9, SLOTS);
        return $urandom_range(SLOTS + 1, SLOTS + 8);
    endfunction

    // one item beat, with random gaps before it
    task automatic send_file(file_beat_t f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {2'b00, f.risk, f.imp, f.mb, f.id};
        s_tlast  <= f.ends_set;
        do @(posedge aclk); while (!s_tready);
        board.note_file(f);
        @(negedge aclk);
    endtask

    // wait for every owed result, then a short settle before touching the register
    task automatic wait_drained();
        s_tvalid <= 0;
        while (board.queued_picks.size() != 0)
            @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        cfg_wvalid <= 1;
        cfg_wdata  <= value;
        do @(posedge aclk); while (!cfg_wready);
        board.capacity = value;
        @(negedge aclk);
        cfg_wvalid <= 0;
    endtask

    initial begin
        file_beat_t prev;
        file_beat_t f;
        int sent;
        int n;
        bit opening;

        board         = new();
        cycles        = 0;
        send_idle_pct = 36;
        recv_idle_pct = 78;
        aresetn       = 0;
        s_tvalid      = 0;
        s_tdata       = '0;
        s_tlast       = 0;
        cfg_wvalid    = 0;
        cfg_wdata     = '0;
        prev          = '0;
        sent          = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // single extreme item that cannot fit the reset capacity
        send_file(make_file(16'hFFFF, 16'hFFFF, 7'h7F, 7'h7F, 1));
        // zero size, zero weight, a density tie, zero risk, and a last item too big to fit
        send_file(make_file(16'h0000, 16'd0,    7'd0,   7'd0,   0));
        send_file(make_file(16'h0101, 16'd100,  7'd50,  7'd20,  0));
        send_file(make_file(16'h0202, 16'd200,  7'd100, 7'd20,  0));
        send_file(make_file(16'h0303, 16'd300,  7'd100, 7'd0,   0));
        send_file(make_file(16'h0404, 16'd500,  7'd100, 7'd100, 0));
        send_file(make_file(16'h0505, 16'd1,    7'd10,  7'd100, 0));
        send_file(make_file(16'h0606, 16'd1000, 7'd127, 7'd127, 1));
        // capacity zero: only a zero-size item fits
        write_capacity('0);
        send_file(make_file(16'h1111, 16'd1, 7'd100, 7'd100, 0));
        send_file(make_file(16'h2222, 16'd0, 7'd10,  7'd1,   1));
        // full capacity: every large item fits
        write_capacity(CAP_MAX);
        send_file(make_file(16'h8000, 16'hFFFF, 7'd100, 7'd100, 0));
        send_file(make_file(16'h7FFF, 16'hFFFF, 7'd64,  7'd64,  0));
        send_file(make_file(16'h00FF, 16'hFFFF, 7'd1,   7'd1,   1));

        // random datasets under three idle mixes, each phase opens with an overflowing set
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 78 : 0;
            recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 36 : 0;
            write_capacity((ph == 0) ? CAP_MAX : (ph == 1) ? CAP_W'(1)
                                                           : CAP_W'($urandom_range(500, 5000)));
            opening = 1;
            while (sent < (ph + 1) * PHASE_ITEMS) begin
                if (!opening && $urandom_range(3) == 0)
                    write_capacity(random_capacity());
                n       = opening ? $urandom_range(SLOTS + 1, SLOTS + 6) : dataset_length();
                opening = 0;
                for (int k = 0; k < n; k++) begin
                    f = random_file(prev, k == n - 1);
                    send_file(f);
                    prev = f;
                    sent++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (board.errors == 0 && board.queued_picks.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
